/* hw/rtl/nearest_centroid_search_unit_defines.svh */
// Assertion macros for the nearest-centroid search unit.
// Included by RTL files that carry concurrent checks; no other dependencies.
`ifndef NEAREST_CENTROID_SEARCH_UNIT_DEFINES_SVH
`define NEAREST_CENTROID_SEARCH_UNIT_DEFINES_SVH

`ifndef SYNTH
`define NCS_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NCS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NCS_ASSERT(name, clk, rst_n, prop, msg)
`define NCS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/ncs_pkg.sv */
// Shared types and constants for the nearest-centroid search unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ncs_pkg;

    localparam int COORD_W = 16;
    localparam int DIST_W  = 38;
    localparam int SQ_W    = 32;

    localparam logic ACTION_CENTROID = 1'b0;
    localparam logic ACTION_POINT    = 1'b1;

    // register index, taken from paddr[2]
    localparam logic REG_CLUSTERS_IN_USE = 1'b0;
    localparam logic REG_DIMS_IN_USE     = 1'b1;

    localparam logic [4:0] CLUSTERS_RESET = 5'd16;
    localparam logic [6:0] DIMS_RESET     = 7'd64;

    typedef struct packed {
        logic                       action;
        logic [3:0]                 cluster_index;
        logic [5:0]                 dim_index;
        logic signed [COORD_W-1:0]  coord_value;
        logic [4:0]                 cluster_limit;
    } req_word_t;

    typedef struct packed {
        logic [3:0]         nearest_cluster;
        logic [DIST_W-1:0]  nearest_distance;
    } rsp_word_t;

    typedef struct packed {
        logic cent_write;
        logic start;
        logic finish;
    } ncs_cmd_t;

    typedef struct packed {
        logic sweep_idle;
        logic point_end;
        logic rsp_free;
    } ncs_status_t;

endpackage

`default_nettype wire

/* hw/rtl/ncs_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ncs_ctrl.sv */
// Controller for the nearest-centroid search unit: accepts words, sequences
// the per-coordinate sweep and the result hand-off. Uses ncs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ncs_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    input  wire logic               req_action,
    output logic                    req_stall,
    input  wire ncs_pkg::ncs_status_t status,
    output ncs_pkg::ncs_cmd_t       cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd.cent_write = 1'b0;
        cmd.start      = 1'b0;
        cmd.finish     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_action == ncs_pkg::ACTION_CENTROID)
                    begin
                        cmd.cent_write = 1'b1;
                    end
                    else
                    begin
                        cmd.start  = 1'b1;
                        state_next = ST_SWEEP;
                    end
                end
            end
            ST_SWEEP:
            begin
                if (status.sweep_idle)
                begin
                    state_next = status.point_end ? ST_FINISH : ST_IDLE;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (status.rsp_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/ncs_datapath.sv */
// Datapath: centroid RAM, partial-distance RAM, a four-stage
// square-accumulate pipeline, running minimum and output register.
// Uses ncs_pkg, ncs_ram and the assertion macros.
`timescale 1ns / 1ps
`default_nettype none
`include "nearest_centroid_search_unit_defines.svh"

module ncs_datapath #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 64
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire ncs_pkg::req_word_t     req_word,
    input  wire logic [4:0]             cfg_clusters,
    input  wire logic [6:0]             cfg_dims,
    input  wire ncs_pkg::ncs_cmd_t      cmd,
    output ncs_pkg::ncs_status_t        status,
    output logic                        rsp_valid,
    input  wire logic                   rsp_stall,
    output ncs_pkg::rsp_word_t          rsp_word
);

    localparam int CW    = $clog2(MAX_CLUSTERS);
    localparam int DW    = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int DEPTH = MAX_CLUSTERS * MAX_DIMS;
    localparam int AW    = $clog2(DEPTH);
    localparam int DSTW  = ncs_pkg::DIST_W;
    localparam int CRW   = ncs_pkg::COORD_W;
    localparam int SQW   = ncs_pkg::SQ_W;

    // effective register values
    logic [4:0] nc_eff;
    logic [6:0] nd_eff;
    logic [4:0] search_eff;
    logic       is_last;

    // control state
    logic [DW-1:0]           count_reg, count_next;
    logic                    last_reg, last_next;
    logic                    issue_reg, issue_next;
    logic [CW-1:0]           k_reg, k_next;
    logic [AW-1:0]           addr_reg, addr_next;
    logic                    s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [MAX_CLUSTERS-1:0] pvalid_reg, pvalid_next;
    logic                    rsp_valid_reg, rsp_valid_next;

    // payload
    logic signed [CRW-1:0]   x_reg;
    logic [4:0]              nc_reg;
    logic [4:0]              search_reg;
    logic [CW-1:0]           s1_k_reg, s2_k_reg, s3_k_reg;
    logic                    s1_pv_reg;
    logic [SQW-1:0]          sq_reg;
    logic [DSTW-1:0]         part_reg;
    logic [DSTW-1:0]         sum_reg;
    logic [CW-1:0]           best_k_reg;
    logic [DSTW-1:0]         best_d_reg;
    ncs_pkg::rsp_word_t      rsp_word_reg;

    // RAM signals
    logic                    cent_we;
    logic [AW-1:0]           cent_waddr;
    logic [CRW-1:0]          cent_rdata;
    logic [DSTW-1:0]         part_rdata;
    logic [DSTW-1:0]         sum;
    logic signed [CRW:0]     diff;
    logic signed [2*CRW+1:0] prod;
    logic                    best_take;

    always_comb
    begin
        if (cfg_clusters == 5'd0)
        begin
            nc_eff = 5'd1;
        end
        else if (32'(cfg_clusters) > MAX_CLUSTERS)
        begin
            nc_eff = 5'(MAX_CLUSTERS);
        end
        else
        begin
            nc_eff = cfg_clusters;
        end

        if (cfg_dims == 7'd0)
        begin
            nd_eff = 7'd1;
        end
        else if (32'(cfg_dims) > MAX_DIMS)
        begin
            nd_eff = 7'(MAX_DIMS);
        end
        else
        begin
            nd_eff = cfg_dims;
        end

        if (req_word.cluster_limit == 5'd0 || req_word.cluster_limit >= nc_eff)
        begin
            search_eff = nc_eff;
        end
        else
        begin
            search_eff = req_word.cluster_limit;
        end

        is_last = ((32'(count_reg) + 1) >= 32'(nd_eff));
    end

    // centroid write decode; out-of-range indexes are dropped
    assign cent_we    = cmd.cent_write
                        && (32'(req_word.cluster_index) < MAX_CLUSTERS)
                        && (32'(req_word.dim_index) < MAX_DIMS);
    assign cent_waddr = AW'(32'(req_word.cluster_index) * MAX_DIMS
                            + 32'(req_word.dim_index));

    ncs_ram #(
        .WIDTH (CRW),
        .DEPTH (DEPTH)
    ) u_cent_ram (
        .clk   (clk),
        .we    (cent_we),
        .waddr (cent_waddr),
        .wdata (req_word.coord_value),
        .re    (issue_reg),
        .raddr (addr_reg),
        .rdata (cent_rdata)
    );

    ncs_ram #(
        .WIDTH (DSTW),
        .DEPTH (MAX_CLUSTERS)
    ) u_part_ram (
        .clk   (clk),
        .we    (s2_valid_reg),
        .waddr (s2_k_reg),
        .wdata (sum),
        .re    (issue_reg),
        .raddr (k_reg),
        .rdata (part_rdata)
    );

    assign diff = {x_reg[CRW-1], x_reg} - {cent_rdata[CRW-1], cent_rdata};
    assign prod = diff * diff;
    assign sum  = part_reg + {{(DSTW-SQW){1'b0}}, sq_reg};

    assign best_take = s3_valid_reg && last_reg && (32'(s3_k_reg) < 32'(search_reg))
                       && ((s3_k_reg == '0) || (sum_reg < best_d_reg));

    always_comb
    begin
        count_next     = count_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        k_next         = k_reg;
        addr_next      = addr_reg;
        pvalid_next    = pvalid_reg;
        rsp_valid_next = rsp_valid_reg;

        if (cmd.start)
        begin
            count_next = is_last ? '0 : DW'(32'(count_reg) + 1);
            last_next  = is_last;
            issue_next = 1'b1;
            k_next     = '0;
            addr_next  = AW'(count_reg);
        end
        else if (issue_reg)
        begin
            k_next    = CW'(32'(k_reg) + 1);
            addr_next = AW'(32'(addr_reg) + MAX_DIMS);
            if ((32'(k_reg) + 1) >= 32'(nc_reg))
            begin
                issue_next = 1'b0;
            end
        end

        if (s2_valid_reg)
        begin
            pvalid_next[s2_k_reg] = 1'b1;
        end

        if (cmd.finish)
        begin
            pvalid_next    = '0;
            rsp_valid_next = 1'b1;
        end
        else if (rsp_valid_reg && !rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            last_reg      <= 1'b0;
            issue_reg     <= 1'b0;
            k_reg         <= '0;
            addr_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            pvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            last_reg      <= last_next;
            issue_reg     <= issue_next;
            k_reg         <= k_next;
            addr_reg      <= addr_next;
            s1_valid_reg  <= issue_reg;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            pvalid_reg    <= pvalid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            x_reg      <= req_word.coord_value;
            nc_reg     <= nc_eff;
            search_reg <= search_eff;
        end
        // stage 1: RAM read in flight
        s1_k_reg  <= k_reg;
        s1_pv_reg <= pvalid_reg[k_reg];
        // stage 2: square; unwritten partials read as zero
        s2_k_reg  <= s1_k_reg;
        sq_reg    <= SQW'(prod);
        part_reg  <= s1_pv_reg ? part_rdata : '0;
        // stage 3: accumulate
        s3_k_reg  <= s2_k_reg;
        sum_reg   <= sum;
        // stage 4: running minimum, lowest index wins ties
        if (best_take)
        begin
            best_k_reg <= s3_k_reg;
            best_d_reg <= sum_reg;
        end
        if (cmd.finish)
        begin
            rsp_word_reg.nearest_cluster  <= 4'(best_k_reg);
            rsp_word_reg.nearest_distance <= best_d_reg;
        end
    end

    assign status.sweep_idle = !issue_reg && !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign status.point_end  = last_reg;
    assign status.rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp_word  = rsp_word_reg;

    `NCS_ASSERT(a_k_in_range, clk, rst_n, issue_reg |-> (32'(k_reg) < 32'(nc_reg)), "sweep index beyond cluster count")
    `NCS_ASSERT(a_no_write_in_sweep, clk, rst_n, !(cmd.cent_write && !status.sweep_idle), "centroid write during sweep")
    `NCS_ASSERT(a_finish_drained, clk, rst_n, cmd.finish |-> status.sweep_idle, "result taken before pipeline drained")
    `NCS_ASSERT_NEXT(a_start_issues, clk, rst_n, cmd.start, issue_reg && (k_reg == '0), "sweep did not start at cluster zero")

endmodule

`default_nettype wire

/* hw/rtl/nearest_centroid_search_unit.sv */
// Top level of the nearest-centroid search unit: APB register file,
// controller and datapath. Uses ncs_pkg, ncs_ctrl, ncs_datapath.
//
// Centroid coordinates are written one word at a time into an on-chip RAM; a
// point arrives one coordinate per word, and each coordinate sweeps a shared
// square-accumulate pipeline over the clusters in use, one cluster per cycle,
// so a point coordinate occupies the block until that pipeline has drained.
// The word that carries the point's last coordinate then also moves the
// nearest index and squared distance into the output register, and waits
// there while an earlier result is still stalled. Centroid writes and
// non-final coordinates are taken while a result waits. Distances are exact
// 38-bit sums; ties go to the lowest index.
`timescale 1ns / 1ps
`default_nettype none

module nearest_centroid_search_unit #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_DIMS     = 64
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // item channel
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire ncs_pkg::req_word_t req_word,
    // result channel
    output logic                    rsp_valid,
    input  wire logic               rsp_stall,
    output ncs_pkg::rsp_word_t      rsp_word,
    // register port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [2:0]         paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic [4:0] clusters_reg;
    logic [6:0] dims_reg;
    logic       reg_write;

    ncs_pkg::ncs_cmd_t    cmd;
    ncs_pkg::ncs_status_t status;

    assign pready    = 1'b1;
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= ncs_pkg::CLUSTERS_RESET;
            dims_reg     <= ncs_pkg::DIMS_RESET;
        end
        else if (reg_write)
        begin
            case (paddr[2])
                ncs_pkg::REG_CLUSTERS_IN_USE: clusters_reg <= pwdata[4:0];
                ncs_pkg::REG_DIMS_IN_USE:     dims_reg     <= pwdata[6:0];
                default:                      dims_reg     <= dims_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ncs_pkg::REG_CLUSTERS_IN_USE: prdata = {27'd0, clusters_reg};
            ncs_pkg::REG_DIMS_IN_USE:     prdata = {25'd0, dims_reg};
            default:                      prdata = '0;
        endcase
    end

    ncs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_action (req_word.action),
        .req_stall  (req_stall),
        .status     (status),
        .cmd        (cmd)
    );

    ncs_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_DIMS     (MAX_DIMS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_word     (req_word),
        .cfg_clusters (clusters_reg),
        .cfg_dims     (dims_reg),
        .cmd          (cmd),
        .status       (status),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .rsp_word     (rsp_word)
    );

endmodule

`default_nettype wire

/* tb/ncs_match_pkg.sv */
// Expected-result tracking for the nearest-centroid search unit testbench:
// a centroid table copy, running distances and the queue of awaited matches.
// Depends on ncs_pkg for the word types and register codes.
`timescale 1ns / 1ps

package ncs_match_pkg;

    localparam int NUM_CLUSTERS = 16;
    localparam int NUM_DIMS     = 64;

    class nearest_match_tracker;

        logic signed [ncs_pkg::COORD_W-1:0] centroid [NUM_CLUSTERS][NUM_DIMS];
        logic [ncs_pkg::DIST_W-1:0]         running [NUM_CLUSTERS];
        int unsigned                        coord_pos;
        logic [4:0]                         clusters_reg;
        logic [6:0]                         dims_reg;
        ncs_pkg::rsp_word_t                 awaited_matches [$];
        int unsigned                        matches_made;
        int unsigned                        mismatches;

        function new();
            foreach (centroid[k, d])
                centroid[k][d] = '0;
            foreach (running[k])
                running[k] = '0;
            coord_pos    = 0;
            clusters_reg = ncs_pkg::CLUSTERS_RESET;
            dims_reg     = ncs_pkg::DIMS_RESET;
            matches_made = 0;
            mismatches   = 0;
        endfunction

        function int unsigned outstanding();
            return awaited_matches.size();
        endfunction

        function void set_register(logic idx, logic [31:0] value);
            if (idx == ncs_pkg::REG_CLUSTERS_IN_USE)
                clusters_reg = value[4:0];
            else
                dims_reg = value[6:0];
        endfunction

        // out-of-range register values saturate; zero acts as one
        function int unsigned active_clusters();
            if (clusters_reg == 0)
                return 1;
            if (clusters_reg > NUM_CLUSTERS)
                return NUM_CLUSTERS;
            return clusters_reg;
        endfunction

        function int unsigned active_dims();
            if (dims_reg == 0)
                return 1;
            if (dims_reg > NUM_DIMS)
                return NUM_DIMS;
            return dims_reg;
        endfunction

        function void take_word(ncs_pkg::req_word_t w);
            int unsigned                nc;
            int unsigned                nd;
            int unsigned                pos;
            int unsigned                reach;
            int unsigned                best;
            int unsigned                k;
            longint                     diff;
            logic [ncs_pkg::DIST_W-1:0] best_dist;
            ncs_pkg::rsp_word_t         match;
            if (w.action == ncs_pkg::ACTION_CENTROID)
            begin
                centroid[w.cluster_index][w.dim_index] = w.coord_value;
                return;
            end
            nc  = active_clusters();
            nd  = active_dims();
            pos = (coord_pos >= NUM_DIMS) ? NUM_DIMS - 1 : coord_pos;
            for (k = 0; k < nc; k++)
            begin
                diff = longint'($signed(w.coord_value)) - longint'(centroid[k][pos]);
                running[k] = running[k] + diff * diff;
            end
            if (coord_pos + 1 < nd)
            begin
                coord_pos++;
                return;
            end
            reach = (w.cluster_limit == 0 || w.cluster_limit >= nc) ? nc : w.cluster_limit;
            best = 0;
            best_dist = running[0];
            // strict compare keeps the lowest index on ties
            for (k = 1; k < reach; k++)
            begin
                if (running[k] < best_dist)
                begin
                    best_dist = running[k];
                    best = k;
                end
            end
            match.nearest_cluster  = 4'(best);
            match.nearest_distance = best_dist;
            awaited_matches.insert(awaited_matches.size(), match);
            matches_made++;
            foreach (running[i])
                running[i] = '0;
            coord_pos = 0;
        endfunction

        function void check_match(ncs_pkg::rsp_word_t got);
            ncs_pkg::rsp_word_t want;
            if (awaited_matches.size() == 0)
            begin
                $display("%0t: result with none awaited: cluster %0d distance %0d",
                         $time, got.nearest_cluster, got.nearest_distance);
                mismatches++;
                return;
            end
            want = awaited_matches.pop_front();
            if (got.nearest_cluster !== want.nearest_cluster)
            begin
                $display("%0t: nearest_cluster expected %0d got %0d",
                         $time, want.nearest_cluster, got.nearest_cluster);
                mismatches++;
            end
            if (got.nearest_distance !== want.nearest_distance)
            begin
                $display("%0t: nearest_distance expected %0d got %0d",
                         $time, want.nearest_distance, got.nearest_distance);
                mismatches++;
            end
        endfunction

    endclass

endpackage

/* tb/tb_top.sv */
// Self-checking testbench for nearest_centroid_search_unit: fills the centroid
// table, runs directed and random points under several register settings.
// Depends on ncs_pkg and ncs_match_pkg.
`timescale 1ns / 1ps

module tb_top;

    localparam int RANDOM_ITEMS    = 240;
    localparam int FILLED_DIMS     = 8;
    localparam int SETTLE_CYCLES   = 40;
    localparam int WATCHDOG_CYCLES = 4000;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    ncs_pkg::req_word_t req_word;
    logic               rsp_valid;
    logic               rsp_stall;
    ncs_pkg::rsp_word_t rsp_word;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    logic        steady = 1'b0;
    int unsigned quiet_cycles = 0;

    ncs_match_pkg::nearest_match_tracker track = new();

    nearest_centroid_search_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_word  (req_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [ncs_pkg::COORD_W-1:0] random_coord();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($signed($urandom_range(0, 8)) - 4);
            default: return 16'($urandom());
        endcase
    endfunction

    function automatic ncs_pkg::req_word_t centroid_word(int unsigned k, int unsigned d,
                                                         logic [ncs_pkg::COORD_W-1:0] value);
        ncs_pkg::req_word_t w;
        w.action        = ncs_pkg::ACTION_CENTROID;
        w.cluster_index = 4'(k);
        w.dim_index     = 6'(d);
        w.coord_value   = value;
        w.cluster_limit = 5'($urandom_range(0, 16));
        return w;
    endfunction

    // index fields are don't-care on points, so randomize them anyway
    function automatic ncs_pkg::req_word_t point_word(logic [ncs_pkg::COORD_W-1:0] value,
                                                      int unsigned limit);
        ncs_pkg::req_word_t w;
        w.action        = ncs_pkg::ACTION_POINT;
        w.cluster_index = 4'($urandom_range(0, 15));
        w.dim_index     = 6'($urandom_range(0, 63));
        w.coord_value   = value;
        w.cluster_limit = 5'(limit);
        return w;
    endfunction

    function automatic ncs_pkg::req_word_t random_word();
        int unsigned limit;
        limit = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
        if ($urandom_range(0, 99) < 85)
            return point_word(random_coord(), limit);
        return centroid_word($urandom_range(0, 15), $urandom_range(0, 63), random_coord());
    endfunction

    task automatic send_word(input ncs_pkg::req_word_t w);
        int unsigned gap;
        @(negedge clk);
        req_word  = w;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        gap = idle_len();
        if (gap != 0)
        begin
            @(negedge clk);
            req_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic drain();
        @(negedge clk);
        req_valid = 1'b0;
        while (track.outstanding() != 0)
            @(posedge clk);
    endtask

    // a word that ends no point may still be in the sweep when the queue empties
    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic idx, input logic [31:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        track.set_register(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_shape(input int unsigned clusters, input int unsigned dims);
        write_register(ncs_pkg::REG_CLUSTERS_IN_USE, 32'(clusters));
        write_register(ncs_pkg::REG_DIMS_IN_USE, 32'(dims));
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (rsp_valid === 1'b1 && rsp_stall === 1'b0)
                track.check_match(rsp_word);
            if (req_valid === 1'b1 && req_stall === 1'b0)
                track.take_word(req_word);
            if ((rsp_valid === 1'b1 && rsp_stall === 1'b0) ||
                (req_valid === 1'b1 && req_stall === 1'b0))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result-side backpressure
    initial
    begin
        int unsigned run;
        run = 0;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (run == 0)
            begin
                if (!steady && $urandom_range(0, 99) < 35)
                begin
                    rsp_stall = 1'b1;
                    run = idle_len() + 1;
                end
                else
                begin
                    rsp_stall = 1'b0;
                    run = steady ? 1 : $urandom_range(1, 16);
                end
            end
            run--;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_CYCLES);
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_CYCLES);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        int unsigned k;
        int unsigned d;
        int unsigned phase;
        int unsigned n;
        int unsigned phase_len;
        int unsigned items;
        int unsigned clusters;
        int unsigned dims;

        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_word  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // leading coordinates of every centroid written first; no shape below
        // uses more than FILLED_DIMS coordinates, so no search reads an unwritten entry
        for (k = 0; k < ncs_match_pkg::NUM_CLUSTERS; k++)
            for (d = 0; d < FILLED_DIMS; d++)
                send_word(centroid_word(k, d, random_coord()));

        settle();
        set_shape(4, 2);
        send_word(centroid_word(0, 0, 16'sd100));
        send_word(centroid_word(0, 1, -16'sd100));
        send_word(centroid_word(1, 0, -16'sd5));
        send_word(centroid_word(1, 1, 16'sd7));
        send_word(centroid_word(2, 0, -16'sd5));
        send_word(centroid_word(2, 1, 16'sd7));
        send_word(centroid_word(3, 0, 16'h7fff));
        send_word(centroid_word(3, 1, 16'h8000));
        // opposite corner of the range from cluster 3
        send_word(point_word(16'h8000, 0));
        send_word(point_word(16'h7fff, 0));
        // clusters 1 and 2 tie at zero
        send_word(point_word(-16'sd5, 0));
        send_word(point_word(16'sd7, 0));
        send_word(point_word(-16'sd5, 0));
        send_word(point_word(16'sd7, 1));
        // exact hit on cluster 3, first with it cut off by the limit
        send_word(point_word(16'h7fff, 0));
        send_word(point_word(16'h8000, 3));
        send_word(point_word(16'h7fff, 0));
        send_word(point_word(16'h8000, 16));
        // centroid rewritten between two coordinates of one point
        send_word(point_word(16'sd100, 0));
        send_word(centroid_word(0, 1, 16'sd5));
        send_word(point_word(16'sd5, 4));
        // shape changed with a point half done
        send_word(point_word(16'sd0, 0));
        settle();
        set_shape(8, 1);
        send_word(point_word(16'sd0, 0));

        phase = 0;
        items = 0;
        while (items < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0:
                begin
                    clusters = 16;
                    dims     = FILLED_DIMS;
                end
                1:
                begin
                    clusters = 1;
                    dims     = 1;
                end
                2:
                begin
                    clusters = 0;
                    dims     = 0;
                end
                3:
                begin
                    clusters = 31;
                    dims     = FILLED_DIMS;
                end
                default:
                begin
                    clusters = $urandom_range(1, 16);
                    dims = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                      : $urandom_range(7, FILLED_DIMS);
                end
            endcase
            set_shape(clusters, dims);
            steady = (phase == 4);
            phase_len = $urandom_range(20, 60);
            for (n = 0; n < phase_len; n++)
            begin
                // hold off until every awaited result is out
                if ((phase == 1 && n == phase_len / 2) || $urandom_range(0, 59) == 0)
                    drain();
                send_word(random_word());
                items++;
            end
            steady = 1'b0;
            phase++;
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (track.mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/ncs_pkg.sv
hw/rtl/ncs_ram.sv
hw/rtl/ncs_ctrl.sv
hw/rtl/ncs_datapath.sv
hw/rtl/nearest_centroid_search_unit.sv
tb/ncs_match_pkg.sv
tb/tb_top.sv
